### rtl/core/hcft_pkg.sv
// Shared definitions for the chunked frame tracker: phase codes, characters,
// the result record and the hex digit decoder. No dependencies.
package hcft_pkg;

  localparam int SIZE_BITS_DEF = 32;
  localparam int COUNT_BITS    = 32;
  localparam int PHASE_BITS    = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [PHASE_BITS-1:0] PH_SIZE     = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_EXT      = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_SIZE_LF  = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_BODY     = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_BODY_CR  = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_BODY_LF  = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_TR_START = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_TR_LINE  = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_TR_LF    = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_FINAL_LF = 4'd9;
  localparam logic [PHASE_BITS-1:0] PH_DONE     = 4'd10;
  localparam logic [PHASE_BITS-1:0] PH_HALT     = 4'd11;
  localparam logic [PHASE_BITS-1:0] PH_LAST     = 4'd15;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  is_payload;
    logic                  message_done;
    logic                  format_error;
    logic [COUNT_BITS-1:0] bytes_seen;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.value = 4'(c - 8'h30);
    end else if (c >= "a" && c <= "f") begin
      h.value = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/core/http_chunked_frame_tracker_unit.sv
// Chunked body frame tracker top level: framing state, parse logic, result register.
// Latency: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall is low, as the phase and counts update on each accepted byte.
// Reset: rst clears the phase to size-line start, the counts and the result register's valid flag.
// Depends on hcft_pkg, hcft_parse and hcft_out_reg.
module http_chunked_frame_tracker_unit #(
  parameter int SIZE_BITS = hcft_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            is_payload,
  output logic                            message_done,
  output logic                            format_error,
  output logic [hcft_pkg::COUNT_BITS-1:0] bytes_seen
);
  import hcft_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [SIZE_BITS-1:0]  chunk;
  logic [SIZE_BITS-1:0]  chunk_next;
  logic                  digit_seen;
  logic                  digit_seen_next;
  logic [COUNT_BITS-1:0] byte_total;
  logic [COUNT_BITS-1:0] byte_total_next;
  logic                  res_valid;
  logic                  in_accept;
  result_t               res;
  result_t               out_data;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  hcft_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .action          (action),
    .data_byte       (data_byte),
    .phase           (phase),
    .chunk           (chunk),
    .digit_seen      (digit_seen),
    .byte_total      (byte_total),
    .phase_next      (phase_next),
    .chunk_next      (chunk_next),
    .digit_seen_next (digit_seen_next),
    .byte_total_next (byte_total_next),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      chunk      <= '0;
      digit_seen <= 1'b0;
      byte_total <= '0;
    end else if (in_accept) begin
      if (action) begin
        phase      <= PH_SIZE;
        chunk      <= '0;
        digit_seen <= 1'b0;
        byte_total <= '0;
      end else if (res_valid) begin
        phase      <= phase_next;
        chunk      <= chunk_next;
        digit_seen <= digit_seen_next;
        byte_total <= byte_total_next;
      end
    end
  end

  hcft_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept && res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .data      (out_data)
  );

  assign out_byte     = out_data.out_byte;
  assign is_payload   = out_data.is_payload;
  assign message_done = out_data.message_done;
  assign format_error = out_data.format_error;
  assign bytes_seen   = out_data.bytes_seen;

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && action |=> phase == PH_SIZE && chunk == '0 && !digit_seen
      && byte_total == '0)
    else $error("restart did not clear framing state");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> chunk != '0)
    else $error("body phase with zero bytes remaining");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_payload && format_error) && !(message_done && format_error))
    else $error("conflicting result flags");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    in_accept && res_valid && res.format_error |=> phase == PH_HALT)
    else $error("tracker did not halt after framing error");
`endif

endmodule

### rtl/core/hcft_parse.sv
// Per-byte framing decision: next phase, size count, byte count and result.
// Depends on hcft_pkg.
module hcft_parse #(
  parameter int SIZE_BITS = hcft_pkg::SIZE_BITS_DEF
) (
  input  logic                                   action,
  input  logic [7:0]                             data_byte,
  input  logic [hcft_pkg::PHASE_BITS-1:0]        phase,
  input  logic [SIZE_BITS-1:0]                   chunk,
  input  logic                                   digit_seen,
  input  logic [hcft_pkg::COUNT_BITS-1:0]        byte_total,
  output logic [hcft_pkg::PHASE_BITS-1:0]        phase_next,
  output logic [SIZE_BITS-1:0]                   chunk_next,
  output logic                                   digit_seen_next,
  output logic [hcft_pkg::COUNT_BITS-1:0]        byte_total_next,
  output logic                                   res_valid,
  output hcft_pkg::result_t                      res
);
  import hcft_pkg::*;

  hex_t                  hx;
  logic                  active;
  logic                  err;
  logic                  payload;
  logic                  done;
  logic [SIZE_BITS-1:0]  chunk_dec;
  logic [PHASE_BITS-1:0] ph;

  assign hx        = hex_decode(data_byte);
  assign chunk_dec = chunk - SIZE_BITS'(1);
  assign active    = !action && !(phase inside {[PH_DONE : PH_LAST]});

  always_comb begin
    ph              = phase;
    chunk_next      = chunk;
    digit_seen_next = digit_seen;
    err             = 1'b0;
    payload         = 1'b0;
    done            = 1'b0;
    case (phase)
      PH_SIZE: begin
        if (hx.ok) begin
          if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
            err = 1'b1;
          end else begin
            chunk_next      = {chunk[SIZE_BITS-5:0], hx.value};
            digit_seen_next = 1'b1;
          end
        end else if (!digit_seen || data_byte == CH_LF) begin
          err = 1'b1;
        end else if (data_byte == CH_CR) begin
          ph = PH_SIZE_LF;
        end else begin
          ph = PH_EXT;
        end
      end
      PH_EXT: begin
        if (data_byte == CH_CR) ph = PH_SIZE_LF;
        else if (data_byte == CH_LF) err = 1'b1;
      end
      PH_SIZE_LF: begin
        if (data_byte != CH_LF) err = 1'b1;
        else if (chunk == '0) ph = PH_TR_START;
        else ph = PH_BODY;
      end
      PH_BODY: begin
        payload    = 1'b1;
        chunk_next = chunk_dec;
        if (chunk_dec == '0) ph = PH_BODY_CR;
      end
      PH_BODY_CR: begin
        if (data_byte == CH_CR) ph = PH_BODY_LF;
        else err = 1'b1;
      end
      PH_BODY_LF: begin
        if (data_byte == CH_LF) begin
          ph              = PH_SIZE;
          digit_seen_next = 1'b0;
          chunk_next      = '0;
        end else begin
          err = 1'b1;
        end
      end
      PH_TR_START: begin
        if (data_byte == CH_CR) ph = PH_FINAL_LF;
        else if (data_byte == CH_LF) err = 1'b1;
        else ph = PH_TR_LINE;
      end
      PH_TR_LINE: begin
        if (data_byte == CH_CR) ph = PH_TR_LF;
        else if (data_byte == CH_LF) err = 1'b1;
      end
      PH_TR_LF: begin
        if (data_byte == CH_LF) ph = PH_TR_START;
        else err = 1'b1;
      end
      PH_FINAL_LF: begin
        if (data_byte == CH_LF) begin
          ph   = PH_DONE;
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        ph = phase;
      end
    endcase
    if (err) ph = PH_HALT;
  end

  assign phase_next       = ph;
  assign byte_total_next  = byte_total + COUNT_BITS'(1);
  assign res_valid        = active;
  assign res.out_byte     = data_byte;
  assign res.is_payload   = payload;
  assign res.message_done = done;
  assign res.format_error = err;
  assign res.bytes_seen   = byte_total_next;

endmodule

### rtl/core/hcft_out_reg.sv
// Result register: holds one result item until the downstream side takes it.
// Depends on hcft_pkg.
module hcft_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hcft_pkg::result_t load_data,
  input  logic              out_stall,
  output logic              out_valid,
  output hcft_pkg::result_t data
);
  import hcft_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
